/* design/sldc_pkg.sv */
// Shared types and constants for the sprite layout command decoder.
package sldc_pkg;

  // Field widths
  localparam int unsigned WRITE_ADDR_W = 18;
  localparam int unsigned MASK_W       = 4;
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CMD_W        = 16;

  // Stream word widths
  localparam int unsigned IN_DATA_W  = BYTE_W + 4 * PIX_W;
  localparam int unsigned OUT_DATA_W = 56;

  // Parameter defaults and register reset
  localparam int unsigned ADDR_BITS_DEFAULT = 18;
  localparam logic [CMD_W-1:0] LIMIT_RESET = 16'hFFFF;

  // Layout opcodes
  localparam logic [BYTE_W-1:0] OP_SET_MASK = 8'd0;
  localparam logic [BYTE_W-1:0] OP_SKIP     = 8'd1;
  localparam logic [BYTE_W-1:0] OP_DRAW     = 8'd2;
  localparam logic [BYTE_W-1:0] OP_END      = 8'd3;

  // Byte-decoding phase
  typedef enum logic [3:0] {
    PH_OPCODE  = 4'b0001,
    PH_MASK    = 4'b0010,
    PH_SKIP_LO = 4'b0100,
    PH_SKIP_HI = 4'b1000
  } phase_t;

endpackage

/* design/sprite_layout_command_decoder_core.sv */
// Sprite layout command decoder: byte decode, pointer update and result register.

// Takes one layout byte per clock, unless a result waits unread, with its four
// palette indices and decodes the frame's command stream: set mask, skip,
// draw, end. Each byte is handled by a short decode plus one pointer add and a
// 16-bit command count compare, so the block sustains one word per cycle while
// the output is read. Draws and frame ends are registered from their byte into
// a single output register; a new byte is taken whenever that register is empty
// or being read, so the input stalls only while a result waits unread. A
// finished frame swallows bytes until a word with start_frame set. command_limit
// may be written only while the block is idle.
module sprite_layout_command_decoder_core #(
  parameter int unsigned ADDR_BITS = sldc_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration: command_limit
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sldc_pkg::CMD_W-1:0]          cfg_data,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: layout_byte, pixel_a, pixel_b, pixel_c, pixel_d (from bit 0 up)
  input  logic [sldc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: start_frame
  input  logic                                s_axis_tuser,
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: write_addr, write_mask, out_a, out_b, out_c, out_d, zero pad
  output logic [sldc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // tlast: frame_done
  output logic                                m_axis_tlast
);

  localparam int unsigned PIX_W  = sldc_pkg::PIX_W;
  localparam int unsigned WIDE_W = (ADDR_BITS > sldc_pkg::WRITE_ADDR_W) ?
                                   ADDR_BITS : sldc_pkg::WRITE_ADDR_W;
  localparam int unsigned PAD_W  = sldc_pkg::OUT_DATA_W - sldc_pkg::WRITE_ADDR_W
                                   - sldc_pkg::MASK_W - 4 * PIX_W;

  // Configuration register
  logic [sldc_pkg::CMD_W-1:0] command_limit;

  // Frame state
  sldc_pkg::phase_t                phase, phase_next;
  logic [sldc_pkg::MASK_W-1:0]     draw_mask, draw_mask_next;
  logic [ADDR_BITS-1:0]            write_pointer, write_pointer_next;
  logic [sldc_pkg::BYTE_W-1:0]     skip_low, skip_low_next;
  logic [sldc_pkg::CMD_W-1:0]      command_count, command_count_next;
  logic                            finished, finished_next;

  // Result register
  logic [sldc_pkg::WRITE_ADDR_W-1:0] write_addr;
  logic [sldc_pkg::MASK_W-1:0]       write_mask;
  logic [PIX_W-1:0]                  out_a, out_b, out_c, out_d;
  logic                              frame_done;

  // Decode signals
  logic                          accept;
  logic                          emit;
  logic [sldc_pkg::BYTE_W-1:0]   layout_byte;
  sldc_pkg::phase_t              ph_cur;
  logic [sldc_pkg::MASK_W-1:0]   mask_cur;
  logic [ADDR_BITS-1:0]          ptr_cur;
  logic [sldc_pkg::BYTE_W-1:0]   lo_cur;
  logic [sldc_pkg::CMD_W-1:0]    cnt_cur;
  logic                          fin_cur;
  logic [sldc_pkg::CMD_W-1:0]    cnt_inc;
  logic                          res_draw;
  logic                          res_done;
  logic [ADDR_BITS-1:0]          res_ptr;
  logic [WIDE_W-1:0]             res_ptr_wide;

  assign layout_byte   = s_axis_tdata[sldc_pkg::BYTE_W-1:0];
  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Apply start of frame, then decode the byte
  always_comb begin
    if (s_axis_tuser) begin
      ph_cur   = sldc_pkg::PH_OPCODE;
      mask_cur = '0;
      ptr_cur  = '0;
      lo_cur   = '0;
      cnt_cur  = '0;
      fin_cur  = 1'b0;
    end else begin
      ph_cur   = phase;
      mask_cur = draw_mask;
      ptr_cur  = write_pointer;
      lo_cur   = skip_low;
      cnt_cur  = command_count;
      fin_cur  = finished;
    end
    cnt_inc = cnt_cur + sldc_pkg::CMD_W'(1);

    phase_next         = ph_cur;
    draw_mask_next     = mask_cur;
    write_pointer_next = ptr_cur;
    skip_low_next      = lo_cur;
    command_count_next = cnt_cur;
    finished_next      = fin_cur;
    emit               = 1'b0;
    res_draw           = 1'b0;
    res_done           = 1'b0;
    res_ptr            = ptr_cur;

    if (!fin_cur) begin
      case (ph_cur)
        sldc_pkg::PH_MASK: begin
          draw_mask_next     = layout_byte[sldc_pkg::MASK_W-1:0];
          write_pointer_next = '0;
          phase_next         = sldc_pkg::PH_OPCODE;
          res_ptr            = '0;
          if (cnt_cur >= command_limit) begin
            finished_next = 1'b1;
            emit          = 1'b1;
            res_done      = 1'b1;
          end
        end
        sldc_pkg::PH_SKIP_LO: begin
          skip_low_next = layout_byte;
          phase_next    = sldc_pkg::PH_SKIP_HI;
        end
        sldc_pkg::PH_SKIP_HI: begin
          write_pointer_next = ptr_cur +
                               ADDR_BITS'({layout_byte, lo_cur, 2'b00});
          phase_next         = sldc_pkg::PH_OPCODE;
          res_ptr            = write_pointer_next;
          if (cnt_cur >= command_limit) begin
            finished_next = 1'b1;
            emit          = 1'b1;
            res_done      = 1'b1;
          end
        end
        default: begin
          if (cnt_cur >= command_limit) begin
            // limit already reached: drop the byte and close the frame
            finished_next = 1'b1;
            emit          = 1'b1;
            res_done      = 1'b1;
          end else begin
            command_count_next = cnt_inc;
            case (layout_byte)
              sldc_pkg::OP_SET_MASK: phase_next = sldc_pkg::PH_MASK;
              sldc_pkg::OP_SKIP:     phase_next = sldc_pkg::PH_SKIP_LO;
              sldc_pkg::OP_DRAW: begin
                emit               = 1'b1;
                res_draw           = 1'b1;
                res_done           = (cnt_inc >= command_limit);
                finished_next      = (cnt_inc >= command_limit);
                write_pointer_next = ptr_cur + ADDR_BITS'(4);
              end
              sldc_pkg::OP_END: begin
                finished_next = 1'b1;
                emit          = 1'b1;
                res_done      = 1'b1;
              end
              default: begin
                // unknown opcode only counts, and closes the frame once the limit is reached
                if (cnt_inc >= command_limit) begin
                  finished_next = 1'b1;
                  emit          = 1'b1;
                  res_done      = 1'b1;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  // Show the low address bits of the pointer
  assign res_ptr_wide = WIDE_W'(res_ptr);

  // Hold the command limit
  always_ff @(posedge clk) begin
    if (rst) begin
      command_limit <= sldc_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      command_limit <= cfg_data;
    end
  end

  // Advance frame state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sldc_pkg::PH_OPCODE;
      draw_mask     <= '0;
      write_pointer <= '0;
      skip_low      <= '0;
      command_count <= '0;
      finished      <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      draw_mask     <= draw_mask_next;
      write_pointer <= write_pointer_next;
      skip_low      <= skip_low_next;
      command_count <= command_count_next;
      finished      <= finished_next;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      write_addr <= res_ptr_wide[sldc_pkg::WRITE_ADDR_W-1:0];
      write_mask <= res_draw ? mask_cur : '0;
      out_a      <= res_draw ? s_axis_tdata[1*PIX_W +: PIX_W] : '0;
      out_b      <= res_draw ? s_axis_tdata[2*PIX_W +: PIX_W] : '0;
      out_c      <= res_draw ? s_axis_tdata[3*PIX_W +: PIX_W] : '0;
      out_d      <= res_draw ? s_axis_tdata[4*PIX_W +: PIX_W] : '0;
      frame_done <= res_done;
    end
  end

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_d, out_c, out_b, out_a, write_mask, write_addr};
  assign m_axis_tlast = frame_done;

endmodule

/* design/sldc_checker.sv */
// Port-level checks for the sprite layout command decoder, bound to the decoder core.
module sldc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [sldc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tlast
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // An empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // A new result only follows an accepted word
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without an accepted word");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind sprite_layout_command_decoder_core sldc_checker u_sldc_checker (.*);

/* test/sprite_layout_command_decoder_core_tb.sv */
// Self-checking testbench for the sprite layout command decoder core.
module sprite_layout_command_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WRITE_ADDR_W    = sldc_pkg::WRITE_ADDR_W;
  localparam int unsigned MASK_W          = sldc_pkg::MASK_W;
  localparam int unsigned PIX_W           = sldc_pkg::PIX_W;
  localparam int unsigned BYTE_W          = sldc_pkg::BYTE_W;
  localparam int unsigned CMD_W           = sldc_pkg::CMD_W;
  localparam int unsigned IN_DATA_W       = sldc_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W      = sldc_pkg::OUT_DATA_W;
  localparam int unsigned ADDR_BITS       = sldc_pkg::ADDR_BITS_DEFAULT;
  localparam int unsigned LIMIT_CYCLES    = 400000;
  localparam int unsigned WORDS_PER_PHASE = 140;
  localparam int unsigned PIX_LSB         = WRITE_ADDR_W + MASK_W;
  localparam int unsigned MAX_PRINTED     = 100;

  typedef logic [3:0][PIX_W-1:0] pix_group_t;

  // One expected four-pixel write (or pure frame end)
  typedef struct packed {
    logic [WRITE_ADDR_W-1:0] addr;
    logic [MASK_W-1:0]       mask;
    pix_group_t              pix;
    logic                    done;
  } pixel_write_t;

  // Tracks the decoder's frame state and the writes it still owes
  class layout_decoder_model;
    logic [CMD_W-1:0]     cmd_limit;
    sldc_pkg::phase_t     phase;
    logic [MASK_W-1:0]    draw_mask;
    logic [ADDR_BITS-1:0] wr_ptr;
    logic [BYTE_W-1:0]    skip_lo;
    logic [CMD_W-1:0]     cmd_count;
    bit                   finished;
    pixel_write_t         pending_writes[$];
    int unsigned          mismatches;

    function new();
      cmd_limit  = sldc_pkg::LIMIT_RESET;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase     = sldc_pkg::PH_OPCODE;
      draw_mask = '0;
      wr_ptr    = '0;
      skip_lo   = '0;
      cmd_count = '0;
      finished  = 1'b0;
    endfunction

    function void push_write(logic [MASK_W-1:0] mask, pix_group_t pix, logic done);
      pixel_write_t w;
      w.addr = wr_ptr[WRITE_ADDR_W-1:0];
      w.mask = mask;
      w.pix  = pix;
      w.done = done;
      pending_writes = {pending_writes, w};
    endfunction

    function void end_frame();
      finished = 1'b1;
      push_write('0, '0, 1'b1);
    endfunction

    // Decode one accepted word; return 0 when the word is swallowed
    function bit take_byte(bit start, logic [BYTE_W-1:0] b, pix_group_t pix);
      logic [31:0] skip;
      if (start) clear_frame();
      if (finished) return 1'b0;
      case (phase)
        sldc_pkg::PH_MASK: begin
          draw_mask = b[MASK_W-1:0];
          wr_ptr    = '0;
          phase     = sldc_pkg::PH_OPCODE;
        end
        sldc_pkg::PH_SKIP_LO: begin
          skip_lo = b;
          phase   = sldc_pkg::PH_SKIP_HI;
          return 1'b1;
        end
        sldc_pkg::PH_SKIP_HI: begin
          skip   = {16'd0, b, skip_lo};
          wr_ptr = ADDR_BITS'(wr_ptr + skip * 4);
          phase  = sldc_pkg::PH_OPCODE;
        end
        default: begin
          // limit already reached when the opcode arrives
          if (cmd_count >= cmd_limit) begin
            end_frame();
            return 1'b1;
          end
          cmd_count = cmd_count + CMD_W'(1);
          if (b == sldc_pkg::OP_SET_MASK) begin
            phase = sldc_pkg::PH_MASK;
            return 1'b1;
          end
          if (b == sldc_pkg::OP_SKIP) begin
            phase = sldc_pkg::PH_SKIP_LO;
            return 1'b1;
          end
          if (b == sldc_pkg::OP_DRAW) begin
            finished = (cmd_count >= cmd_limit);
            push_write(draw_mask, pix, finished);
            wr_ptr = ADDR_BITS'(wr_ptr + 4);
            return 1'b1;
          end
          if (b == sldc_pkg::OP_END) begin
            end_frame();
            return 1'b1;
          end
        end
      endcase
      // limit checked once the command's last byte is taken
      if (cmd_count >= cmd_limit) end_frame();
      return 1'b1;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one result word against the oldest owed write
    task check_write(logic [OUT_DATA_W-1:0] d, logic last);
      pixel_write_t w;
      int j;
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected word addr=%0h last=%0b",
                                  d[WRITE_ADDR_W-1:0], last));
        return;
      end
      w = pending_writes.pop_front();
      if (d[WRITE_ADDR_W-1:0] !== w.addr)
        report_mismatch($sformatf("write_addr %0h, want %0h", d[WRITE_ADDR_W-1:0], w.addr));
      if (d[WRITE_ADDR_W +: MASK_W] !== w.mask)
        report_mismatch($sformatf("write_mask %0h, want %0h", d[WRITE_ADDR_W +: MASK_W], w.mask));
      for (j = 0; j < 4; j++) begin
        if (d[PIX_LSB + j*PIX_W +: PIX_W] !== w.pix[j])
          report_mismatch($sformatf("pixel %0d is %0h, want %0h", j,
                                    d[PIX_LSB + j*PIX_W +: PIX_W], w.pix[j]));
      end
      if (last !== w.done)
        report_mismatch($sformatf("frame_done %0b, want %0b", last, w.done));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CMD_W-1:0]      cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  layout_decoder_model model = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent_words     = 0;
  int unsigned cycles         = 0;

  sprite_layout_command_decoder_core #(
    .ADDR_BITS(ADDR_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Check result words and stall the output at random
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) model.check_write(m_axis_tdata, m_axis_tlast);
      m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  function automatic pix_group_t rand_pix();
    return pix_group_t'($urandom());
  endfunction

  // Offer one word, holding it until accepted
  task automatic send_word(bit start, logic [BYTE_W-1:0] b, pix_group_t pix);
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= start;
    s_axis_tdata  <= {pix, b};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    void'(model.take_byte(start, b, pix));
    sent_words++;
  endtask

  // Send an opcode with its operand bytes
  task automatic send_cmd(bit start, logic [BYTE_W-1:0] op);
    logic [15:0] skip;
    send_word(start, op, rand_pix());
    if (op == sldc_pkg::OP_SET_MASK) begin
      send_word(1'b0, BYTE_W'($urandom_range(255, 0)), rand_pix());
    end else if (op == sldc_pkg::OP_SKIP) begin
      skip = ($urandom_range(99, 0) < 15) ? 16'($urandom()) : 16'($urandom_range(8, 0));
      send_word(1'b0, skip[7:0], rand_pix());
      send_word(1'b0, skip[15:8], rand_pix());
    end
  endtask

  // Drain all owed writes, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (model.pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [CMD_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model.cmd_limit = value;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frame with random content, some noise mixed in
  task automatic random_frame();
    int n;
    int k;
    int sel;
    bit start;
    n = ($urandom_range(9, 0) == 0) ? $urandom_range(80, 30) : $urandom_range(20, 1);
    for (k = 0; k < n; k++) begin
      sel   = $urandom_range(99, 0);
      start = (k == 0);
      if (sel < 40)      send_cmd(start, sldc_pkg::OP_DRAW);
      else if (sel < 55) send_cmd(start, sldc_pkg::OP_SET_MASK);
      else if (sel < 70) send_cmd(start, sldc_pkg::OP_SKIP);
      else if (sel < 74) send_cmd(start, sldc_pkg::OP_END);
      else if (sel < 86) send_cmd(start, BYTE_W'($urandom_range(255, 4)));
      else send_word(start || ($urandom_range(99, 0) < 20),
                     BYTE_W'($urandom_range(255, 0)), rand_pix());
    end
    if ($urandom_range(3, 0) != 0) send_cmd(1'b0, sldc_pkg::OP_END);
    // a trailing byte after the end goes nowhere
    if ($urandom_range(4, 0) == 0) send_word(1'b0, BYTE_W'($urandom()), rand_pix());
  endtask

  initial begin
    logic [CMD_W-1:0] limits [10];
    int p;
    int unsigned target;
    limits = '{16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd5, 16'd13,
               CMD_W'($urandom_range(60, 6)), 16'hFFFF, 16'd3, CMD_W'($urandom())};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: pixel extremes, ignored mask high bits, pointer wrap, unknown opcodes, end and restart
    send_cmd(1'b1, sldc_pkg::OP_SET_MASK);
    send_word(1'b0, sldc_pkg::OP_DRAW, {4{8'hFF}});
    send_word(1'b0, sldc_pkg::OP_SKIP, rand_pix());
    send_word(1'b0, 8'hFF, rand_pix());
    send_word(1'b0, 8'hFF, rand_pix());
    send_word(1'b0, sldc_pkg::OP_DRAW, '0);
    send_word(1'b0, 8'hFF, rand_pix());
    send_word(1'b0, 8'd4, rand_pix());
    send_word(1'b0, sldc_pkg::OP_SET_MASK, rand_pix());
    send_word(1'b0, 8'hF0, rand_pix());
    send_word(1'b0, sldc_pkg::OP_DRAW, rand_pix());
    send_word(1'b0, sldc_pkg::OP_SET_MASK, rand_pix());
    send_word(1'b0, 8'h05, rand_pix());
    send_word(1'b0, sldc_pkg::OP_DRAW, rand_pix());
    send_word(1'b0, sldc_pkg::OP_END, rand_pix());
    send_word(1'b0, sldc_pkg::OP_DRAW, rand_pix());
    send_word(1'b1, sldc_pkg::OP_DRAW, rand_pix());
    send_word(1'b0, sldc_pkg::OP_SKIP, rand_pix());
    send_word(1'b0, 8'h34, rand_pix());
    send_word(1'b0, 8'h12, rand_pix());
    send_word(1'b0, sldc_pkg::OP_DRAW, rand_pix());

    // Lower the limit mid-frame: the next opcode ends the frame
    write_limit(16'd1);
    send_word(1'b0, sldc_pkg::OP_DRAW, rand_pix());
    send_word(1'b1, sldc_pkg::OP_DRAW, rand_pix());
    write_limit(16'd0);
    send_word(1'b1, sldc_pkg::OP_SET_MASK, rand_pix());
    write_limit(16'd2);
    send_cmd(1'b1, sldc_pkg::OP_SET_MASK);
    send_word(1'b0, sldc_pkg::OP_DRAW, rand_pix());

    // Random frames across limits and idling patterns
    for (p = 0; p < 10; p++) begin
      write_limit(limits[p]);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 57;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 57;
        end
        default: begin
          send_idle_pct  = 23;
          recv_stall_pct = 23;
        end
      endcase
      target = sent_words + WORDS_PER_PHASE;
      while (sent_words < target) random_frame();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (model.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
